// ===== design/rc_pkg.sv =====
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types, constants and helper functions for the radix converter.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE   = 2'd1;

  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
  localparam logic [BASE_W-1:0] DEST_BASE_RST   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_MIN        = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX        = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [4:0] DIG_TEN  = 5'd10;
  localparam logic [4:0] DIG_BAD  = 5'd16;  // marks a non-hex character

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       bad_number;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FETCH,
    ST_PUT
  } rc_state_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // 0..15 for a hex digit, DIG_BAD otherwise
  function automatic logic [4:0] char_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      return t[4:0];
    end
    if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA;
      return t[4:0] + DIG_TEN;
    end
    if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA;
      return t[4:0] + DIG_TEN;
    end
    return DIG_BAD;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    if ({1'b0, d} < DIG_TEN) return CH_ZERO + {4'd0, d};
    return CH_UA + {4'd0, d} - {3'd0, DIG_TEN};
  endfunction

endpackage

// ===== design/rc_divider.sv =====
// ----------------------------------------------------------------------------
// rc_divider
// Restoring divider, one quotient bit per cycle, for a divisor of 2 to 16.
// ----------------------------------------------------------------------------
module rc_divider #(
  parameter int W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [W-1:0]              dividend,
  input  logic [rc_pkg::BASE_W-1:0] divisor,
  output logic [W-1:0]              quotient,
  output rc_pkg::div_status_t       status
);
  import rc_pkg::*;

  localparam int CW = $clog2(W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [W-1:0]      x_r, x_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BASE_W-1:0] d_r, d_nxt;
  logic [BASE_W-1:0] trial;
  logic [BASE_W-1:0] diff;
  logic              ge;

  // remainder stays below the divisor, so the shifted trial fits in 5 bits
  assign trial = {rem_r, x_r[W-1]};
  assign ge    = trial >= d_r;
  assign diff  = trial - d_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      x_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      x_nxt   = {x_r[W-2:0], ge};
      rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient    = x_r;
  assign status.done = done_r;
  assign status.rem  = rem_r;

endmodule

// ===== design/radix_converter.sv =====
// ----------------------------------------------------------------------------
// radix_converter
// Reads a number as ASCII digits in one radix and emits it in another.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry one ASCII character and an is_last flag, most
//   significant digit first. A character that is not the final one is
//   accepted while in_stall is low and yields no result. The final character
//   starts the conversion: the value is divided repeatedly by dest_base in a
//   bit-serial divider, then the digits are read back from a small digit RAM,
//   each through a fetch state and a put state. From the final character
//   until the last digit or the error item enters the output register,
//   in_stall is high. An invalid number gives one error item (bad_number
//   set). Results go out through an output register; when out_stall is high
//   the item waits there and the sequencer holds. A new number may start
//   while the last digit of the previous one still waits. cfg_we writes
//   source_base (index 0) or dest_base (index 1); the user must write them
//   only while idle, and the block itself does not enforce it. Reset (rst_n
//   low, synchronous) clears the accumulator, error flag and output valid,
//   and loads the bases with 10 and 16.
// ----------------------------------------------------------------------------
module radix_converter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rc_pkg::in_item_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rc_pkg::out_item_t             out_data,
  input  logic                          cfg_we,
  input  logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  rc_state_t state_r, state_nxt;

  logic [BASE_W-1:0]     src_base_r, dst_base_r;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  inv_r, inv_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [DIGIT_W-1:0]    rd_data_r;
  logic [DIGIT_W-1:0]    mem [MAX_DIGITS];

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_acc;
  logic                  slot_free;
  logic [BASE_W-1:0]     sb;
  logic [4:0]            cval;
  logic                  digit_bad;
  logic [VALUE_BITS-1:0] digit_ext;
  logic [VALUE_BITS-1:0] step_val;

  logic                  div_start;
  logic                  mem_we;
  logic [VALUE_BITS-1:0] quotient;
  div_status_t           div_stat;

  rc_divider #(.W(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (clamp_base(dst_base_r)),
    .quotient (quotient),
    .status   (div_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign sb        = clamp_base(src_base_r);
  assign cval      = char_value(in_data.char_in);
  assign digit_bad = (cval == DIG_BAD) || (cval >= sb);
  assign digit_ext = (cval == DIG_BAD) ? '0 : VALUE_BITS'(cval);
  assign step_val  = acc_r * VALUE_BITS'(sb) + digit_ext;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    inv_nxt       = inv_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.is_last) begin
            acc_nxt = '0;
            inv_nxt = 1'b0;
            val_nxt = step_val;
            cnt_nxt = '0;
            state_nxt = (inv_r || digit_bad) ? ST_ERR : ST_DIV_START;
          end else begin
            acc_nxt = step_val;
            inv_nxt = inv_r || digit_bad;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_out   = '0;
          out_data_nxt.bad_number = 1'b1;
          out_data_nxt.last_out   = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          mem_we  = 1'b1;
          val_nxt = quotient;
          cnt_nxt = cnt_r + 1'b1;
          // stop on a zero quotient or when the digit RAM is full
          if (quotient == '0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            rd_idx_nxt = cnt_r[IDX_W-1:0];
            state_nxt  = ST_FETCH;
          end else begin
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_out   = digit_char(rd_data_r);
          out_data_nxt.bad_number = 1'b0;
          out_data_nxt.last_out   = (rd_idx_r == '0);
          if (rd_idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
            state_nxt  = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      inv_r       <= 1'b0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
      src_base_r  <= SOURCE_BASE_RST;
      dst_base_r  <= DEST_BASE_RST;
    end else begin
      acc_r       <= acc_nxt;
      inv_r       <= inv_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOURCE_BASE: src_base_r <= cfg_data;
          CFG_DEST_BASE:   dst_base_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  // digit RAM: written LSD first, read back in reverse
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= div_stat.rem;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/rc_checker.sv =====
// ----------------------------------------------------------------------------
// rc_checker
// Port-level checks on the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
module rc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input rc_pkg::out_item_t out_data
);
  import rc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_number |-> out_data.last_out && out_data.char_out == 8'd0)
    else $error("error item is not a lone zero item");

  a_digit_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_number |->
      (out_data.char_out >= CH_ZERO && out_data.char_out <= CH_NINE) ||
      (out_data.char_out >= CH_UA && out_data.char_out <= CH_UF))
    else $error("emitted character is not an uppercase hex digit");

endmodule

bind radix_converter rc_checker u_rc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/radix_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter_checker
// Watches the character, digit and register ports of the radix converter.
// It keeps its own copy of the accumulator, error flag and both bases, works
// out the digits each final character should produce, and compares every
// accepted result item against the oldest expected one.
// ----------------------------------------------------------------------------
module radix_converter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  rc_pkg::in_item_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  rc_pkg::out_item_t             out_data,
  input  logic                          cfg_we,
  input  logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            numbers_done,
  output int                            numbers_bad
);
  import rc_pkg::*;

  localparam int         VBITS   = 32;
  localparam int         DIG_CAP = 32;
  localparam logic [4:0] NOT_HEX = 5'd16;

  out_item_t          digits_due[$];
  out_item_t          want;
  logic [VBITS-1:0]   acc_value;
  logic               bad_seen;
  logic [BASE_W-1:0]  src_radix;
  logic [BASE_W-1:0]  dst_radix;

  function automatic logic [4:0] eff_radix(input logic [BASE_W-1:0] r);
    if (r < BASE_MIN) return BASE_MIN;
    else if (r > BASE_MAX) return BASE_MAX;
    return r;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] off;
    off = 8'hFF;
    if (c >= CH_ZERO && c <= CH_NINE) off = c - CH_ZERO;
    else if (c >= CH_UA && c <= CH_UF) off = c - CH_UA + 8'd10;
    else if (c >= CH_LA && c <= CH_LF) off = c - CH_LA + 8'd10;
    return (off == 8'hFF) ? NOT_HEX : off[4:0];
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    return (d < 4'd10) ? CH_ZERO + {4'd0, d} : CH_UA + {4'd0, d} - 8'd10;
  endfunction

  // accumulate one character; the final one queues the digits it must yield
  task automatic take_char(input in_item_t it);
    logic [4:0]       sb;
    logic [4:0]       db;
    logic [4:0]       dv;
    logic [VBITS-1:0] x;
    logic [VBITS-1:0] rm;
    logic [3:0]       digs [DIG_CAP];
    int               n;
    out_item_t        r;
    sb = eff_radix(src_radix);
    dv = hex_value(it.char_in);
    if (dv == NOT_HEX) begin
      bad_seen = 1'b1;
      dv = 5'd0;
    end else if (dv >= sb) begin
      bad_seen = 1'b1;
    end
    acc_value = acc_value * sb + dv;
    if (it.is_last) begin
      numbers_done++;
      if (bad_seen) begin
        numbers_bad++;
        r.char_out = 8'd0;
        r.bad_number = 1'b1;
        r.last_out = 1'b1;
        digits_due.push_back(r);
      end else begin
        db = eff_radix(dst_radix);
        x = acc_value;
        n = 0;
        do begin
          rm = x % db;
          digs[n] = rm[3:0];
          n++;
          x = x / db;
        end while (x != 0 && n < DIG_CAP);
        for (int k = n - 1; k >= 0; k--) begin
          r.char_out = hex_glyph(digs[k]);
          r.bad_number = 1'b0;
          r.last_out = (k == 0);
          digits_due.push_back(r);
        end
      end
      acc_value = '0;
      bad_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_value = '0;
      bad_seen = 1'b0;
      src_radix = SOURCE_BASE_RST;
      dst_radix = DEST_BASE_RST;
      digits_due.delete();
    end else begin
      // a register written at this edge only counts from the next item on
      if (in_valid && !in_stall) take_char(in_data);
      if (cfg_we) begin
        if (cfg_index == CFG_SOURCE_BASE) src_radix = cfg_data;
        else if (cfg_index == CFG_DEST_BASE) dst_radix = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (digits_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: char %h bad %b last %b",
                     out_data.char_out, out_data.bad_number, out_data.last_out);
        end else begin
          want = digits_due.pop_front();
          checked++;
          if (out_data.char_out !== want.char_out ||
              out_data.bad_number !== want.bad_number ||
              out_data.last_out !== want.last_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected char %h bad %b last %b, got char %h bad %b last %b",
                       checked, want.char_out, want.bad_number, want.last_out,
                       out_data.char_out, out_data.bad_number, out_data.last_out);
          end
        end
      end
    end
    pending = digits_due.size();
  end

endmodule

// ===== tb/radix_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter_tb
// Feeds the radix converter numbers as ASCII strings: a directed set of
// corner numbers and bases first, then random numbers under random bases,
// with random gaps and stalls and one long receiver hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module radix_converter_tb;
  import rc_pkg::*;

  localparam int                   HOLD_CYCLES = 400;
  localparam int                   RAND_ITEMS  = 130;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int numbers_done;
  int numbers_bad;

  logic [BASE_W-1:0] src_now = SOURCE_BASE_RST;
  logic              in_calm = 1'b0;
  logic              out_calm = 1'b0;
  int                hold_asks = 0;
  int                items_sent = 0;

  radix_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  radix_converter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .numbers_done(numbers_done), .numbers_bad(numbers_bad)
  );

  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !out_calm && ($urandom_range(99) < 20);
      end
    end
  end

  function automatic logic [7:0] digit_ascii(input int v);
    return (v < 10) ? 8'(CH_ZERO + v) : 8'(CH_UA + v - 10);
  endfunction

  function automatic int radix_in_use();
    if (src_now < BASE_MIN) return int'(BASE_MIN);
    else if (src_now > BASE_MAX) return int'(BASE_MAX);
    return int'(src_now);
  endfunction

  // returns right after the edge that took the item
  task automatic send_char(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while (!in_calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.char_in <= ch;
    in_data.is_last <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_random_number();
    int len;
    int sb;
    int v;
    int pick;
    logic [7:0] ch;
    sb = radix_in_use();
    len = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        ch = 8'($urandom_range(255));
      end else if (pick < 10 && sb < 16) begin
        ch = digit_ascii($urandom_range(15, sb));
      end else begin
        v = $urandom_range(sb - 1);
        ch = digit_ascii(v);
        if (v >= 10 && $urandom_range(1)) ch = ch + 8'h20;  // lowercase
      end
      send_char(ch, i == len - 1);
    end
  endtask

  // block is idle once every queued digit is out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE_BASE) src_now = d;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_base();
    // mostly legal radices, some that the block must saturate
    if ($urandom_range(99) < 80) return CFG_DATA_W'($urandom_range(16, 2));
    return ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(1, 0))
                                    : CFG_DATA_W'($urandom_range(31, 17));
  endfunction

  initial begin
    int rand_start;
    int phase;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // base 10 in, base 16 out after reset
    send_text("0");
    send_text("255");
    send_text("1A");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    settle();
    write_reg(CFG_SOURCE_BASE, 5'd16);
    write_reg(CFG_DEST_BASE, 5'd2);
    send_text("fFfFfFfF");            // 32 binary digits
    settle();
    write_reg(CFG_SOURCE_BASE, 5'd0);
    write_reg(CFG_DEST_BASE, 5'd1);
    send_text("10");
    settle();
    write_reg(CFG_SOURCE_BASE, 5'd31);
    write_reg(CFG_DEST_BASE, 5'd17);
    write_reg(CFG_SPARE_A, 5'd3);
    write_reg(CFG_SPARE_B, 5'd31);
    send_text("100000000");           // wraps to zero

    rand_start = items_sent;
    phase = 0;
    while (items_sent - rand_start < RAND_ITEMS) begin
      settle();
      in_calm = (phase == 2);
      out_calm = (phase == 2);
      if (phase == 0) begin
        // long binary answers pile up behind a stalled receiver
        write_reg(CFG_SOURCE_BASE, 5'd16);
        write_reg(CFG_DEST_BASE, 5'd2);
        hold_asks++;
      end else begin
        write_reg(CFG_SOURCE_BASE, random_base());
        write_reg(CFG_DEST_BASE, random_base());
        if ($urandom_range(4) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                    CFG_DATA_W'($urandom_range(31)));
      end
      repeat ($urandom_range(6, 3)) send_random_number();
      phase++;
    end

    in_calm = 1'b0;
    out_calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("%0d characters sent as %0d numbers (%0d invalid), %0d result items checked",
             items_sent, numbers_done, numbers_bad, checked);
    $display("bases swept across 0..31 in %0d random phases, one %0d-cycle receiver hold",
             phase, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
